FILE: design/i2cmr_pkg.sv
// ----------------------------------------------------------------------------
// i2cmr_pkg
// Shared types and constants for the I2C master read engine.
// ----------------------------------------------------------------------------
package i2cmr_pkg;

    // Longest transfer accepted; larger counts are clamped to this
    localparam int unsigned MAX_READ_LEN = 255;

    localparam logic [15:0] HALF_PERIOD_RESET   = 16'd90;
    localparam logic [23:0] TIMEOUT_LIMIT_RESET = 24'd65535;
    localparam logic [23:0] ELAPSED_MAX         = 24'hFFFFFF;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_HALF_PERIOD   = 1'b0,
        CFG_TIMEOUT_LIMIT = 1'b1
    } cfg_index_t;

    // Transfer outcome
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ADDR_NACK = 2'd1,
        STATUS_TIMEOUT   = 2'd2
    } status_t;

    // Bus sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_A     = 5'd1,
        PH_ST_B     = 5'd2,
        PH_ST_C     = 5'd3,
        PH_WR_DATA  = 5'd4,
        PH_WR_HIGH  = 5'd5,
        PH_WR_LOW   = 5'd6,
        PH_AK_REL   = 5'd7,
        PH_AK_HIGH  = 5'd8,
        PH_AK_LOW   = 5'd9,
        PH_RD_SETUP = 5'd10,
        PH_RD_HIGH  = 5'd11,
        PH_RD_LOW   = 5'd12,
        PH_RA_DRIVE = 5'd13,
        PH_RA_HIGH  = 5'd14,
        PH_RA_LOW   = 5'd15,
        PH_SP_A     = 5'd16,
        PH_SP_B     = 5'd17,
        PH_SP_C     = 5'd18
    } phase_t;

endpackage

FILE: design/i2c_master_read_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_read_engine
// Bit-banged I2C master that reads a run of bytes from a seven-bit target,
// paced by a half-period divider, one tick item per clock unless m_ready stalls.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                  Handshake    Moves
//  --------  -------------------------------------  -----------  -----------------
//  input     s_command .. s_sda_in                  s_valid/rdy  one tick item
//  result    m_scl_out .. m_busy_res                m_valid/rdy  one result item
//  config    cfg_wr_en, cfg_index, cfg_wdata        write only   one register
//
//  Each accepted tick item updates the sequencer state and lands its result
//  in the output register at the same edge; one item per cycle is sustained
//  while m_ready takes each result.
//  s_ready is high while the output register is empty or being taken, so a
//  stalled m_ready holds the input side after at most one item.
//  aresetn (synchronous, active low) returns the sequencer to idle with both
//  lines released and the registers at their reset values; no clearing pass.
//
module i2c_master_read_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    // tick items in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [6:0]  s_slave_address,
    input  logic [7:0]  s_byte_count,
    input  logic        s_sda_in,
    // results out
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_out,
    output logic        m_sda_out,
    output logic [7:0]  m_data_byte,
    output logic        m_data_valid,
    output logic        m_last_byte,
    output logic        m_done_res,
    output logic [1:0]  m_status,
    output logic        m_busy_res
);

    // Configuration registers
    logic [15:0] half_period_reg;
    logic [23:0] timeout_limit_reg;

    // Sequencer state
    i2cmr_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]        divider_count_reg, divider_count_next;
    logic [23:0]        elapsed_ticks_reg, elapsed_ticks_next;
    logic [3:0]         bit_index_reg, bit_index_next;
    logic [7:0]         bytes_left_reg, bytes_left_next;
    logic [7:0]         shift_reg, shift_next;
    logic               scl_drive_reg, scl_drive_next;
    logic               sda_drive_reg, sda_drive_next;
    i2cmr_pkg::status_t pending_status_reg, pending_status_next;

    // Per-tick result flags
    logic               res_valid;
    logic [7:0]         res_byte;
    logic               res_last;
    logic               res_done;
    i2cmr_pkg::status_t res_status;

    // Output register
    logic               m_valid_reg;
    logic               out_scl_reg, out_sda_reg;
    logic [7:0]         out_byte_reg;
    logic               out_dvalid_reg, out_last_reg, out_done_reg, out_busy_reg;
    i2cmr_pkg::status_t out_status_reg;

    // Shared decode
    logic        accept;
    logic        busy;
    logic [15:0] hp;
    logic [15:0] div_inc;
    logic        adv;
    logic [23:0] elapsed_inc;
    logic        timed_out;
    logic [7:0]  cnt_clamp;
    logic [3:0]  bi_dec;
    logic [3:0]  bi_inc;
    logic [7:0]  bl_dec;
    logic [7:0]  rx_shift;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    assign busy        = (phase_reg != i2cmr_pkg::PH_IDLE);
    // A half period of zero behaves as one
    assign hp          = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
    assign div_inc     = divider_count_reg + 16'd1;
    assign adv         = busy & (div_inc >= hp);
    // Saturate the elapsed count at its maximum
    assign elapsed_inc = (elapsed_ticks_reg == i2cmr_pkg::ELAPSED_MAX) ?
                         elapsed_ticks_reg : (elapsed_ticks_reg + 24'd1);
    assign timed_out   = (elapsed_inc > timeout_limit_reg);
    assign cnt_clamp   = (32'(s_byte_count) > i2cmr_pkg::MAX_READ_LEN) ?
                         8'(i2cmr_pkg::MAX_READ_LEN) : s_byte_count;
    assign bi_dec      = bit_index_reg - 4'd1;
    assign bi_inc      = bit_index_reg + 4'd1;
    assign bl_dec      = (bytes_left_reg != 8'd0) ? (bytes_left_reg - 8'd1) : bytes_left_reg;
    assign rx_shift    = {shift_reg[6:0], s_sda_in};

    // ------------------------------------------------------------------
    // Next phase
    // ------------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        if (!busy) begin
            if (s_command && (cnt_clamp != 8'd0)) begin
                phase_next = i2cmr_pkg::PH_ST_A;
            end
        end else if (adv) begin
            case (phase_reg)
                i2cmr_pkg::PH_ST_A:     phase_next = i2cmr_pkg::PH_ST_B;
                i2cmr_pkg::PH_ST_B:     phase_next = i2cmr_pkg::PH_ST_C;
                i2cmr_pkg::PH_ST_C: begin
                    phase_next = timed_out ? i2cmr_pkg::PH_IDLE : i2cmr_pkg::PH_WR_DATA;
                end
                i2cmr_pkg::PH_WR_DATA:  phase_next = i2cmr_pkg::PH_WR_HIGH;
                i2cmr_pkg::PH_WR_HIGH:  phase_next = i2cmr_pkg::PH_WR_LOW;
                i2cmr_pkg::PH_WR_LOW: begin
                    phase_next = (bit_index_reg != 4'd0) ? i2cmr_pkg::PH_WR_DATA
                                                          : i2cmr_pkg::PH_AK_REL;
                end
                i2cmr_pkg::PH_AK_REL:   phase_next = i2cmr_pkg::PH_AK_HIGH;
                i2cmr_pkg::PH_AK_HIGH:  phase_next = i2cmr_pkg::PH_AK_LOW;
                i2cmr_pkg::PH_AK_LOW: begin
                    if (shift_reg[0]) begin
                        phase_next = i2cmr_pkg::PH_SP_A;
                    end else begin
                        phase_next = timed_out ? i2cmr_pkg::PH_IDLE : i2cmr_pkg::PH_RD_SETUP;
                    end
                end
                i2cmr_pkg::PH_RD_SETUP: phase_next = i2cmr_pkg::PH_RD_HIGH;
                i2cmr_pkg::PH_RD_HIGH:  phase_next = i2cmr_pkg::PH_RD_LOW;
                i2cmr_pkg::PH_RD_LOW: begin
                    phase_next = bit_index_reg[3] ? i2cmr_pkg::PH_RA_DRIVE
                                                  : i2cmr_pkg::PH_RD_SETUP;
                end
                i2cmr_pkg::PH_RA_DRIVE: phase_next = i2cmr_pkg::PH_RA_HIGH;
                i2cmr_pkg::PH_RA_HIGH:  phase_next = i2cmr_pkg::PH_RA_LOW;
                i2cmr_pkg::PH_RA_LOW: begin
                    if (bl_dec != 8'd0) begin
                        phase_next = timed_out ? i2cmr_pkg::PH_IDLE
                                               : i2cmr_pkg::PH_RD_SETUP;
                    end else begin
                        phase_next = i2cmr_pkg::PH_SP_A;
                    end
                end
                i2cmr_pkg::PH_SP_A:     phase_next = i2cmr_pkg::PH_SP_B;
                i2cmr_pkg::PH_SP_B:     phase_next = i2cmr_pkg::PH_SP_C;
                i2cmr_pkg::PH_SP_C:     phase_next = i2cmr_pkg::PH_IDLE;
                default:                phase_next = i2cmr_pkg::PH_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath and result flags
    // ------------------------------------------------------------------
    always_comb begin
        divider_count_next  = divider_count_reg;
        elapsed_ticks_next  = elapsed_ticks_reg;
        bit_index_next      = bit_index_reg;
        bytes_left_next     = bytes_left_reg;
        shift_next          = shift_reg;
        scl_drive_next      = scl_drive_reg;
        sda_drive_next      = sda_drive_reg;
        pending_status_next = pending_status_reg;
        res_valid           = 1'b0;
        res_byte            = 8'd0;
        res_last            = 1'b0;
        res_done            = 1'b0;
        res_status          = i2cmr_pkg::STATUS_OK;

        if (!busy) begin
            if (s_command) begin
                if (cnt_clamp == 8'd0) begin
                    // empty transfer: report success at once
                    res_done = 1'b1;
                end else begin
                    elapsed_ticks_next  = 24'd0;
                    divider_count_next  = 16'd0;
                    bit_index_next      = 4'd0;
                    bytes_left_next     = cnt_clamp;
                    shift_next          = {s_slave_address, 1'b1};
                    pending_status_next = i2cmr_pkg::STATUS_OK;
                    sda_drive_next      = 1'b1;
                    scl_drive_next      = 1'b1;
                end
            end
        end else begin
            elapsed_ticks_next = elapsed_inc;
            divider_count_next = adv ? 16'd0 : div_inc;
            if (adv) begin
                case (phase_reg)
                    i2cmr_pkg::PH_ST_A:    sda_drive_next = 1'b0;
                    i2cmr_pkg::PH_ST_B:    scl_drive_next = 1'b0;
                    i2cmr_pkg::PH_ST_C: begin
                        if (timed_out) begin
                            scl_drive_next = 1'b1;
                            sda_drive_next = 1'b1;
                            res_done       = 1'b1;
                            res_status     = i2cmr_pkg::STATUS_TIMEOUT;
                        end else begin
                            bit_index_next = 4'd7;
                            sda_drive_next = shift_reg[7];
                        end
                    end
                    i2cmr_pkg::PH_WR_DATA: scl_drive_next = 1'b1;
                    i2cmr_pkg::PH_WR_HIGH: scl_drive_next = 1'b0;
                    i2cmr_pkg::PH_WR_LOW: begin
                        if (bit_index_reg != 4'd0) begin
                            bit_index_next = {1'b0, bi_dec[2:0]};
                            sda_drive_next = shift_reg[bi_dec[2:0]];
                        end else begin
                            sda_drive_next = 1'b1;
                        end
                    end
                    i2cmr_pkg::PH_AK_REL:  scl_drive_next = 1'b1;
                    i2cmr_pkg::PH_AK_HIGH: begin
                        shift_next     = {7'd0, s_sda_in};
                        scl_drive_next = 1'b0;
                    end
                    i2cmr_pkg::PH_AK_LOW: begin
                        if (shift_reg[0]) begin
                            // address not acknowledged: go to STOP
                            pending_status_next = i2cmr_pkg::STATUS_ADDR_NACK;
                            sda_drive_next      = 1'b0;
                        end else if (timed_out) begin
                            scl_drive_next = 1'b1;
                            sda_drive_next = 1'b1;
                            res_done       = 1'b1;
                            res_status     = i2cmr_pkg::STATUS_TIMEOUT;
                        end else begin
                            sda_drive_next = 1'b1;
                            bit_index_next = 4'd0;
                            shift_next     = 8'd0;
                        end
                    end
                    i2cmr_pkg::PH_RD_SETUP: scl_drive_next = 1'b1;
                    i2cmr_pkg::PH_RD_HIGH: begin
                        shift_next     = rx_shift;
                        scl_drive_next = 1'b0;
                        bit_index_next = bi_inc;
                        if (bi_inc[3]) begin
                            res_valid = 1'b1;
                            res_byte  = rx_shift;
                            res_last  = (bytes_left_reg == 8'd1);
                        end
                    end
                    i2cmr_pkg::PH_RD_LOW: begin
                        if (bit_index_reg[3]) begin
                            // ACK all but the last byte
                            sda_drive_next = (bytes_left_reg > 8'd1) ? 1'b0 : 1'b1;
                        end
                    end
                    i2cmr_pkg::PH_RA_DRIVE: scl_drive_next = 1'b1;
                    i2cmr_pkg::PH_RA_HIGH:  scl_drive_next = 1'b0;
                    i2cmr_pkg::PH_RA_LOW: begin
                        bytes_left_next = bl_dec;
                        if (bl_dec != 8'd0) begin
                            if (timed_out) begin
                                scl_drive_next = 1'b1;
                                sda_drive_next = 1'b1;
                                res_done       = 1'b1;
                                res_status     = i2cmr_pkg::STATUS_TIMEOUT;
                            end else begin
                                sda_drive_next = 1'b1;
                                bit_index_next = 4'd0;
                                shift_next     = 8'd0;
                            end
                        end else begin
                            pending_status_next = i2cmr_pkg::STATUS_OK;
                            sda_drive_next      = 1'b0;
                        end
                    end
                    i2cmr_pkg::PH_SP_A: scl_drive_next = 1'b1;
                    i2cmr_pkg::PH_SP_B: sda_drive_next = 1'b1;
                    i2cmr_pkg::PH_SP_C: begin
                        res_done   = 1'b1;
                        res_status = pending_status_reg;
                    end
                    default: begin
                        res_done = 1'b0;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg   <= i2cmr_pkg::HALF_PERIOD_RESET;
            timeout_limit_reg <= i2cmr_pkg::TIMEOUT_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                i2cmr_pkg::CFG_HALF_PERIOD:   half_period_reg   <= cfg_wdata[15:0];
                i2cmr_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_wdata;
                default:                      half_period_reg   <= half_period_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state: advance only on an accepted tick item
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= i2cmr_pkg::PH_IDLE;
            divider_count_reg  <= 16'd0;
            elapsed_ticks_reg  <= 24'd0;
            bit_index_reg      <= 4'd0;
            bytes_left_reg     <= 8'd0;
            shift_reg          <= 8'd0;
            scl_drive_reg      <= 1'b1;
            sda_drive_reg      <= 1'b1;
            pending_status_reg <= i2cmr_pkg::STATUS_OK;
        end else if (accept) begin
            phase_reg          <= phase_next;
            divider_count_reg  <= divider_count_next;
            elapsed_ticks_reg  <= elapsed_ticks_next;
            bit_index_reg      <= bit_index_next;
            bytes_left_reg     <= bytes_left_next;
            shift_reg          <= shift_next;
            scl_drive_reg      <= scl_drive_next;
            sda_drive_reg      <= sda_drive_next;
            pending_status_reg <= pending_status_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on accept, drop once taken
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_scl_reg    <= scl_drive_next;
            out_sda_reg    <= sda_drive_next;
            out_byte_reg   <= res_byte;
            out_dvalid_reg <= res_valid;
            out_last_reg   <= res_last;
            out_done_reg   <= res_done;
            out_status_reg <= res_status;
            out_busy_reg   <= (phase_next != i2cmr_pkg::PH_IDLE);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_scl_out    = out_scl_reg;
    assign m_sda_out    = out_sda_reg;
    assign m_data_byte  = out_byte_reg;
    assign m_data_valid = out_dvalid_reg;
    assign m_last_byte  = out_last_reg;
    assign m_done_res   = out_done_reg;
    assign m_status     = out_status_reg;
    assign m_busy_res   = out_busy_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_divider_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == i2cmr_pkg::PH_IDLE) |-> (divider_count_reg == 16'd0))
        else $error("divider running while idle");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done reported while still busy");

    a_byte_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data_valid) |-> (!m_done_res && m_busy_res))
        else $error("byte completed outside a running transfer");

    a_status_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_done_res) |-> (m_status == i2cmr_pkg::STATUS_OK))
        else $error("status set without done");

    a_last_with_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_byte) |-> m_data_valid)
        else $error("last byte flag without a byte");

endmodule

FILE: tb/sv/tb_i2c_master_read_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_read_engine
// Self-checking bench for the I2C master read engine. A queue of tick items,
// mostly well-formed read transfers with random line data, feeds a
// valid/ready driver with random gaps. Every accepted tick runs through a
// cycle-exact model of the bus sequencer, and each result item is compared
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_i2c_master_read_engine;

    // One input tick: optional start command plus the sampled data line
    typedef struct {
        logic       command;
        logic [6:0] slave_address;
        logic [7:0] byte_count;
        logic       sda_in;
    } tick_item_t;

    // Line drives and event flags produced by one tick
    typedef struct {
        logic                scl;
        logic                sda;
        logic [7:0]          data;
        logic                data_valid;
        logic                last;
        logic                done;
        i2cmr_pkg::status_t  status;
        logic                busy;
    } bus_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = i2cmr_pkg::CFG_HALF_PERIOD;
    logic [23:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = 1'b0;
    logic [6:0]  s_slave_address = '0;
    logic [7:0]  s_byte_count = '0;
    logic        s_sda_in = 1'b1;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_scl_out;
    logic        m_sda_out;
    logic [7:0]  m_data_byte;
    logic        m_data_valid;
    logic        m_last_byte;
    logic        m_done_res;
    logic [1:0]  m_status;
    logic        m_busy_res;

    i2c_master_read_engine u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_slave_address (s_slave_address),
        .s_byte_count    (s_byte_count),
        .s_sda_in        (s_sda_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scl_out       (m_scl_out),
        .m_sda_out       (m_sda_out),
        .m_data_byte     (m_data_byte),
        .m_data_valid    (m_data_valid),
        .m_last_byte     (m_last_byte),
        .m_done_res      (m_done_res),
        .m_status        (m_status),
        .m_busy_res      (m_busy_res)
    );

    // Stimulus and expectation stores
    tick_item_t  tick_queue[$];
    bus_result_t results_due[$];
    int unsigned errors_seen = 0;
    int unsigned ticks_queued = 0;

    // Handshake bookkeeping shared between the edges
    bit          tick_taken = 1'b0;
    bit          pacing_on = 1'b1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;

    // Sequencer model: configuration copy and bus state
    logic [15:0]        cfg_half;
    logic [23:0]        cfg_timeout;
    i2cmr_pkg::phase_t  bus_phase;
    logic [15:0]        div_cnt;
    logic [23:0]        elapsed;
    logic [3:0]         bit_idx;
    logic [7:0]         bytes_left;
    logic [7:0]         shreg;
    logic               scl_drv;
    logic               sda_drv;
    i2cmr_pkg::status_t stop_status;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(64'd20_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Checking helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        errors_seen++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Random idle length: mostly none, some short, a few long
    function automatic int unsigned idle_len();
        int unsigned pick;
        if (!pacing_on)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 100);
    endfunction

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------
    task automatic close_transfer(input i2cmr_pkg::status_t st, inout bus_result_t r);
        bus_phase = i2cmr_pkg::PH_IDLE;
        r.done    = 1'b1;
        r.status  = st;
        div_cnt   = '0;
    endtask

    // Release both lines before reporting a timeout
    task automatic timeout_abort(inout bus_result_t r);
        scl_drv = 1'b1;
        sda_drv = 1'b1;
        close_transfer(i2cmr_pkg::STATUS_TIMEOUT, r);
    endtask

    task automatic open_stop(input i2cmr_pkg::status_t st);
        stop_status = st;
        sda_drv     = 1'b0;
        bus_phase   = i2cmr_pkg::PH_SP_A;
    endtask

    task automatic next_byte(inout bus_result_t r);
        if (elapsed > cfg_timeout) begin
            timeout_abort(r);
        end else begin
            sda_drv   = 1'b1;
            bit_idx   = '0;
            shreg     = '0;
            bus_phase = i2cmr_pkg::PH_RD_SETUP;
        end
    endtask

    task automatic predict_tick(input tick_item_t it, output bus_result_t r);
        logic [15:0] hp;
        logic [7:0]  count;
        hp           = (cfg_half == 16'd0) ? 16'd1 : cfg_half;
        r.data       = '0;
        r.data_valid = 1'b0;
        r.last       = 1'b0;
        r.done       = 1'b0;
        r.status     = i2cmr_pkg::STATUS_OK;

        if (bus_phase == i2cmr_pkg::PH_IDLE) begin
            if (it.command) begin
                count = it.byte_count;
                if (count > i2cmr_pkg::MAX_READ_LEN)
                    count = 8'(i2cmr_pkg::MAX_READ_LEN);
                if (count == 8'd0) begin
                    // empty read completes on the spot, lines untouched
                    r.done   = 1'b1;
                    r.status = i2cmr_pkg::STATUS_OK;
                end else begin
                    elapsed     = '0;
                    div_cnt     = '0;
                    bit_idx     = '0;
                    bytes_left  = count;
                    shreg       = {it.slave_address, 1'b1};
                    stop_status = i2cmr_pkg::STATUS_OK;
                    sda_drv     = 1'b1;
                    scl_drv     = 1'b1;
                    bus_phase   = i2cmr_pkg::PH_ST_A;
                end
            end
        end else begin
            if (elapsed != i2cmr_pkg::ELAPSED_MAX)
                elapsed = elapsed + 24'd1;
            div_cnt = div_cnt + 16'd1;
            if (div_cnt >= hp) begin
                div_cnt = '0;
                case (bus_phase)
                    i2cmr_pkg::PH_ST_A: begin
                        sda_drv = 1'b0; bus_phase = i2cmr_pkg::PH_ST_B;
                    end
                    i2cmr_pkg::PH_ST_B: begin
                        scl_drv = 1'b0; bus_phase = i2cmr_pkg::PH_ST_C;
                    end
                    i2cmr_pkg::PH_ST_C: begin
                        if (elapsed > cfg_timeout) begin
                            timeout_abort(r);
                        end else begin
                            bit_idx   = 4'd7;
                            sda_drv   = shreg[7];
                            bus_phase = i2cmr_pkg::PH_WR_DATA;
                        end
                    end
                    i2cmr_pkg::PH_WR_DATA: begin
                        scl_drv = 1'b1; bus_phase = i2cmr_pkg::PH_WR_HIGH;
                    end
                    i2cmr_pkg::PH_WR_HIGH: begin
                        scl_drv = 1'b0; bus_phase = i2cmr_pkg::PH_WR_LOW;
                    end
                    i2cmr_pkg::PH_WR_LOW: begin
                        if (bit_idx > 4'd0) begin
                            bit_idx   = (bit_idx - 4'd1) & 4'd7;
                            sda_drv   = shreg[bit_idx];
                            bus_phase = i2cmr_pkg::PH_WR_DATA;
                        end else begin
                            sda_drv   = 1'b1;
                            bus_phase = i2cmr_pkg::PH_AK_REL;
                        end
                    end
                    i2cmr_pkg::PH_AK_REL: begin
                        scl_drv = 1'b1; bus_phase = i2cmr_pkg::PH_AK_HIGH;
                    end
                    i2cmr_pkg::PH_AK_HIGH: begin
                        shreg     = {7'd0, it.sda_in};
                        scl_drv   = 1'b0;
                        bus_phase = i2cmr_pkg::PH_AK_LOW;
                    end
                    i2cmr_pkg::PH_AK_LOW: begin
                        if (shreg[0])
                            open_stop(i2cmr_pkg::STATUS_ADDR_NACK);
                        else
                            next_byte(r);
                    end
                    i2cmr_pkg::PH_RD_SETUP: begin
                        scl_drv = 1'b1; bus_phase = i2cmr_pkg::PH_RD_HIGH;
                    end
                    i2cmr_pkg::PH_RD_HIGH: begin
                        shreg   = {shreg[6:0], it.sda_in};
                        scl_drv = 1'b0;
                        bit_idx = bit_idx + 4'd1;
                        if (bit_idx >= 4'd8) begin
                            r.data_valid = 1'b1;
                            r.data       = shreg;
                            r.last       = (bytes_left == 8'd1);
                        end
                        bus_phase = i2cmr_pkg::PH_RD_LOW;
                    end
                    i2cmr_pkg::PH_RD_LOW: begin
                        if (bit_idx < 4'd8) begin
                            bus_phase = i2cmr_pkg::PH_RD_SETUP;
                        end else begin
                            // ACK every byte but the last, which gets a NACK
                            sda_drv   = (bytes_left > 8'd1) ? 1'b0 : 1'b1;
                            bus_phase = i2cmr_pkg::PH_RA_DRIVE;
                        end
                    end
                    i2cmr_pkg::PH_RA_DRIVE: begin
                        scl_drv = 1'b1; bus_phase = i2cmr_pkg::PH_RA_HIGH;
                    end
                    i2cmr_pkg::PH_RA_HIGH: begin
                        scl_drv = 1'b0; bus_phase = i2cmr_pkg::PH_RA_LOW;
                    end
                    i2cmr_pkg::PH_RA_LOW: begin
                        if (bytes_left > 8'd0)
                            bytes_left = bytes_left - 8'd1;
                        if (bytes_left > 8'd0)
                            next_byte(r);
                        else
                            open_stop(i2cmr_pkg::STATUS_OK);
                    end
                    i2cmr_pkg::PH_SP_A: begin
                        scl_drv = 1'b1; bus_phase = i2cmr_pkg::PH_SP_B;
                    end
                    i2cmr_pkg::PH_SP_B: begin
                        sda_drv = 1'b1; bus_phase = i2cmr_pkg::PH_SP_C;
                    end
                    i2cmr_pkg::PH_SP_C: begin
                        close_transfer(stop_status, r);
                    end
                    default: begin
                        bus_phase = i2cmr_pkg::PH_IDLE;
                    end
                endcase
            end
        end

        r.scl  = scl_drv;
        r.sda  = sda_drv;
        r.busy = (bus_phase != i2cmr_pkg::PH_IDLE);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present the next queued tick at the falling edge, with gaps
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : tick_driver
        tick_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || tick_taken) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
                it = tick_queue.pop_front();
                s_command       <= it.command;
                s_slave_address <= it.slave_address;
                s_byte_count    <= it.byte_count;
                s_sda_in        <= it.sda_in;
                s_valid         <= 1'b1;
                gap_left = idle_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: hold m_ready low for random stretches
    always @(negedge aclk) begin : result_pacing
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            stall_left = idle_len();
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results, then predict from the tick accepted this edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : bus_monitor
        bus_result_t want;
        bus_result_t next_res;
        tick_item_t  seen;
        if (!aresetn) begin
            cfg_half    = i2cmr_pkg::HALF_PERIOD_RESET;
            cfg_timeout = i2cmr_pkg::TIMEOUT_LIMIT_RESET;
            bus_phase   = i2cmr_pkg::PH_IDLE;
            div_cnt     = '0;
            elapsed     = '0;
            bit_idx     = '0;
            bytes_left  = '0;
            shreg       = '0;
            scl_drv     = 1'b1;
            sda_drv     = 1'b1;
            stop_status = i2cmr_pkg::STATUS_OK;
            tick_taken  = 1'b0;
            results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want = results_due.pop_front();
                    check_field("scl_out",    8'(m_scl_out),    8'(want.scl));
                    check_field("sda_out",    8'(m_sda_out),    8'(want.sda));
                    check_field("data_byte",  m_data_byte,      want.data);
                    check_field("data_valid", 8'(m_data_valid), 8'(want.data_valid));
                    check_field("last_byte",  8'(m_last_byte),  8'(want.last));
                    check_field("done_res",   8'(m_done_res),   8'(want.done));
                    check_field("status",     8'(m_status),     8'(want.status));
                    check_field("busy_res",   8'(m_busy_res),   8'(want.busy));
                end
            end

            // register writes land at this edge
            if (cfg_wr_en) begin
                if (cfg_index == i2cmr_pkg::CFG_HALF_PERIOD)
                    cfg_half = cfg_wdata[15:0];
                else if (cfg_index == i2cmr_pkg::CFG_TIMEOUT_LIMIT)
                    cfg_timeout = cfg_wdata;
            end

            tick_taken = s_valid && s_ready;
            if (tick_taken) begin
                seen.command       = s_command;
                seen.slave_address = s_slave_address;
                seen.byte_count    = s_byte_count;
                seen.sda_in        = s_sda_in;
                predict_tick(seen, next_res);
                results_due.push_back(next_res);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_tick(input logic cmd, input logic [6:0] addr,
                             input logic [7:0] count, input logic sda);
        tick_item_t it;
        it.command       = cmd;
        it.slave_address = addr;
        it.byte_count    = count;
        it.sda_in        = sda;
        tick_queue.push_back(it);
        ticks_queued++;
    endtask

    task automatic push_plain_ticks(input int unsigned n);
        repeat (n)
            push_tick(1'b0, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    // Wait until the queue is empty and every result is back, then let the
    // output register settle
    task automatic wait_drained();
        while (tick_queue.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Drain, and keep ticking until the sequencer is back to idle
    task automatic settle_idle();
        wait_drained();
        while (bus_phase != i2cmr_pkg::PH_IDLE) begin
            push_plain_ticks(64);
            wait_drained();
        end
    endtask

    task automatic write_reg(input i2cmr_pkg::cfg_index_t idx, input logic [23:0] value);
        settle_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Ticks from the start tick to the end of a transfer under the current
    // settings: timeout checks fall after START and before each data byte
    function automatic longint unsigned transfer_span(input logic [7:0] count,
                                                      input bit nack_addr);
        longint unsigned hp;
        hp = (cfg_half == 16'd0) ? 64'd1 : 64'(cfg_half);
        if (count == 8'd0)
            return 0;
        if (3 * hp > cfg_timeout)
            return 3 * hp;
        if (nack_addr)
            return 33 * hp;
        for (int b = 0; b < count; b++)
            if ((30 + 27 * b) * hp > cfg_timeout)
                return (30 + 27 * b) * hp;
        return (33 + 27 * longint'(count)) * hp;
    endfunction

    // Queue one read transfer: random line data throughout, except the
    // address ACK slot, which the target drives as asked
    task automatic run_transfer(input logic [6:0] addr, input logic [7:0] count,
                                input bit nack_addr, input int unsigned noise_pct);
        longint unsigned hp;
        longint unsigned span;
        hp   = (cfg_half == 16'd0) ? 64'd1 : 64'(cfg_half);
        span = transfer_span(count, nack_addr);
        push_tick(1'b1, addr, count, 1'($urandom_range(0, 1)));
        for (longint unsigned j = 1; j <= span; j++) begin
            if (j % hp == 0 && j / hp == 29)
                push_tick(1'b0, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                          nack_addr);
            else if ($urandom_range(0, 99) < noise_pct)
                // start command while busy: must be ignored
                push_tick(1'b1, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            else
                push_tick(1'b0, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        int unsigned random_start;
        int unsigned setting_left;
        int unsigned pick;
        logic [7:0]  count;
        logic [15:0] hp_pick;
        logic [23:0] limit_pick;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: plain ticks at both field extremes and an empty read
        push_tick(1'b0, 7'h7F, 8'hFF, 1'b1);
        push_tick(1'b0, 7'h00, 8'h00, 1'b0);
        push_tick(1'b1, 7'h7F, 8'h00, 1'b1);

        // Default half period, cut short by a timeout straight after START
        write_reg(i2cmr_pkg::CFG_TIMEOUT_LIMIT, 24'd0);
        run_transfer(7'h7F, 8'd1, 1'b0, 0);

        // Fastest bus, no timeout
        write_reg(i2cmr_pkg::CFG_HALF_PERIOD, 24'd1);
        write_reg(i2cmr_pkg::CFG_TIMEOUT_LIMIT, 24'hFFFFFF);
        run_transfer(7'h00, 8'd1, 1'b0, 0);
        run_transfer(7'h55, 8'd2, 1'b0, 10);
        run_transfer(7'h2A, 8'd255, 1'b1, 5);
        run_transfer(7'h33, 8'd4, 1'b0, 2);
        // pause the sender until every result is back
        wait_drained();

        // Timeout straight after START
        write_reg(i2cmr_pkg::CFG_TIMEOUT_LIMIT, 24'd0);
        run_transfer(7'h11, 8'd4, 1'b0, 0);
        // Timeout ahead of the fourth data byte
        write_reg(i2cmr_pkg::CFG_TIMEOUT_LIMIT, 24'd100);
        run_transfer(7'h22, 8'd10, 1'b0, 0);

        // Zero half period runs as one
        write_reg(i2cmr_pkg::CFG_HALF_PERIOD, 24'd0);
        write_reg(i2cmr_pkg::CFG_TIMEOUT_LIMIT, 24'd40);
        run_transfer(7'h44, 8'd3, 1'b0, 0);

        // Slowest bus: idle ticks and an empty read only
        write_reg(i2cmr_pkg::CFG_HALF_PERIOD, 24'd65535);
        push_tick(1'b1, 7'h66, 8'h00, 1'b0);
        push_plain_ticks(4);
        settle_idle();

        // Random part: bursts of transfers under random settings
        random_start = ticks_queued;
        setting_left = 0;
        while (ticks_queued - random_start < 500) begin
            if (setting_left == 0) begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0:       hp_pick = 16'd0;
                    1, 2:    hp_pick = 16'd1;
                    3:       hp_pick = 16'd2;
                    4:       hp_pick = 16'd3;
                    default: hp_pick = 16'($urandom_range(1, 4));
                endcase
                pick = $urandom_range(0, 3);
                case (pick)
                    0:       limit_pick = 24'hFFFFFF;
                    1:       limit_pick = 24'($urandom_range(0, 300));
                    2:       limit_pick = 24'($urandom_range(60, 200));
                    default: limit_pick = 24'($urandom_range(0, 24'hFFFFFF));
                endcase
                write_reg(i2cmr_pkg::CFG_HALF_PERIOD, {8'd0, hp_pick});
                write_reg(i2cmr_pkg::CFG_TIMEOUT_LIMIT, limit_pick);
                // some settings run with no idling at all
                pacing_on    = ($urandom_range(0, 3) != 0);
                setting_left = $urandom_range(3, 8);
            end

            pick = $urandom_range(0, 99);
            if (pick < 8)
                count = 8'd0;
            else if (pick < 75)
                count = 8'($urandom_range(1, 3));
            else
                count = 8'($urandom_range(4, 10));
            run_transfer(7'($urandom_range(0, 127)), count, ($urandom_range(0, 6) == 0), 3);
            setting_left--;

            if ($urandom_range(0, 1) != 0)
                push_plain_ticks($urandom_range(0, 5));
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        settle_idle();
        repeat (10) @(posedge aclk);
        if (errors_seen == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
